>>> design/sfuc_pkg.sv
package sfuc_pkg;

    // SLIP special bytes
    localparam logic [7:0] DELIM   = 8'hC0;
    localparam logic [7:0] ESC     = 8'hDB;
    localparam logic [7:0] ESC_ESC = 8'hDD;
    localparam logic [7:0] ESC_END = 8'hDC;

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_NIBBLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIAS = 1'b1;

    // reset values of the registers
    localparam logic [3:0] TYPE_NIBBLE_RST = 4'd5;
    localparam logic [7:0] LENGTH_BIAS_RST = 8'd11;

    // raw position of the header byte
    localparam logic [7:0] HDR_POS = 8'd6;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_BAD_LINK = 2'd2;
    localparam logic [1:0] ST_LEN_BAD  = 2'd3;

    // most result words one raw byte can cause
    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [7:0]  length;
        logic [15:0] errors;
        logic        last;
    } t_item;

    // results of one raw byte, first word in slot 0
    typedef struct packed {
        logic [1:0]              count;
        t_item [MAX_RES-1:0]     items;
    } t_bundle;

endpackage

>>> design/slip_frame_unescape_check.sv
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_rx_byte, i_end_of_buffer
// output    out        o_out_valid / i_out_ready   o_item_kind, o_data_byte, o_frame_status,
//                                                  o_decoded_length, o_link_errors, o_last
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A raw byte is decoded in the cycle it is accepted; its 0 to 3 result words
// appear on the output from the next cycle, one word per cycle while the output is ready.
// One raw byte per cycle is sustained while the output is ready and each byte yields at most one word;
// bytes that yield two or three words hold back the next byte while their words drain.
// The next byte is taken in the cycle the last held result word leaves.
// Reset (i_rst_n low at a clock edge) clears frame state, the error count and
// the output queue, and restores the register defaults.
module slip_frame_unescape_check import sfuc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_end_of_buffer,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_item_kind,
    output logic [7:0]           o_data_byte,
    output logic [1:0]           o_frame_status,
    output logic [7:0]           o_decoded_length,
    output logic [15:0]          o_link_errors,
    output logic                 o_last
);

    logic    in_acc;
    logic    room;
    t_bundle bundle;
    t_item   head;

    assign o_in_ready = room;
    assign in_acc     = i_in_valid && room;

    // unescape and frame check
    sfuc_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_acc           (in_acc),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_bundle        (bundle)
    );

    // result words waiting for the output port
    sfuc_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (in_acc),
        .i_bundle (bundle),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_item   (head)
    );

    assign o_item_kind      = head.kind;
    assign o_data_byte      = head.data;
    assign o_frame_status   = head.status;
    assign o_decoded_length = head.length;
    assign o_link_errors    = head.errors;
    assign o_last           = head.last;

endmodule

>>> design/sfuc_decode.sv
module sfuc_decode import sfuc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_acc,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_end_of_buffer,
    output t_bundle              o_bundle
);

    logic [3:0]  r_type;
    logic [7:0]  r_bias;
    logic [7:0]  r_raw;
    logic [7:0]  r_dc;
    logic        r_esc;
    logic [1:0]  r_delim;
    logic        r_first;
    logic [7:0]  r_hdr;
    logic [15:0] r_err;

    logic [7:0]  n_raw;
    logic [7:0]  n_dc;
    logic        n_esc;
    logic [1:0]  n_delim;
    logic        n_first;
    logic [7:0]  n_hdr;
    logic [15:0] n_err;

    logic [1:0]  nd;
    logic [1:0]  nd_tot;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic        esc_step;
    logic [8:0]  dc_sum;
    logic [8:0]  expect_len;
    logic [1:0]  status;
    logic [1:0]  count;

    // unescape one raw byte into at most two data words
    always_comb begin
        nd       = 2'd0;
        d0       = i_rx_byte;
        d1       = ESC;
        esc_step = 1'b0;
        if (r_esc) begin
            if (i_rx_byte == ESC_ESC) begin
                nd = 2'd1;
                d0 = ESC;
            end else if (i_rx_byte == ESC_END) begin
                nd = 2'd1;
                d0 = DELIM;
            end else begin
                d0 = ESC;
                if (i_rx_byte == ESC) begin
                    esc_step = 1'b1;
                    nd       = 2'd1;
                end else begin
                    nd = 2'd2;
                    d1 = i_rx_byte;
                end
            end
        end else if (i_rx_byte == ESC) begin
            esc_step = 1'b1;
        end else begin
            nd = 2'd1;
        end
        // flush an escape still open at the end of the buffer
        nd_tot = nd;
        if (i_end_of_buffer && esc_step) begin
            nd_tot = nd + 2'd1;
            if (nd == 2'd0) begin
                d0 = ESC;
            end else begin
                d1 = ESC;
            end
        end
    end

    // frame bookkeeping
    always_comb begin
        n_esc   = esc_step && !i_end_of_buffer;
        n_first = (r_raw == 8'd0) ? (i_rx_byte == DELIM) : r_first;
        n_hdr   = (r_raw == HDR_POS) ? i_rx_byte : r_hdr;
        n_raw   = (r_raw == 8'hFF) ? r_raw : r_raw + 8'd1;
        n_delim = (i_rx_byte == DELIM && r_delim != 2'd3) ? r_delim + 2'd1 : r_delim;
        dc_sum  = {1'b0, r_dc} + {7'd0, nd_tot};
        n_dc    = dc_sum[8] ? 8'hFF : dc_sum[7:0];
        expect_len = {5'd0, n_hdr[3:0]} + {1'b0, r_bias};
        n_err   = r_err;
        if (n_delim != 2'd2 || !n_first || i_rx_byte != DELIM) begin
            status = ST_IGNORED;
        end else if (n_hdr[7:4] != r_type) begin
            status = ST_BAD_LINK;
            if (i_end_of_buffer && r_err != 16'hFFFF) begin
                n_err = r_err + 16'd1;
            end
        end else begin
            status = ({1'b0, n_dc} == expect_len) ? ST_OK : ST_LEN_BAD;
        end
    end

    // lay out the result words
    always_comb begin
        count = nd_tot + {1'b0, i_end_of_buffer};
        o_bundle.count = count;
        for (int k = 0; k < MAX_RES; k++) begin
            o_bundle.items[k] = '0;
            if (2'(k) < nd_tot) begin
                o_bundle.items[k].kind = KIND_DATA;
                o_bundle.items[k].data = (k == 0) ? d0 : d1;
            end else if (i_end_of_buffer && 2'(k) == nd_tot) begin
                o_bundle.items[k].kind   = KIND_STATUS;
                o_bundle.items[k].status = status;
                o_bundle.items[k].length = n_dc;
                o_bundle.items[k].errors = n_err;
            end
            o_bundle.items[k].last = (2'(k) == count - 2'd1);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= TYPE_NIBBLE_RST;
            r_bias <= LENGTH_BIAS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TYPE_NIBBLE: r_type <= i_cfg_data[3:0];
                CFG_LENGTH_BIAS: r_bias <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance frame state on each accepted word, clear it at buffer end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= '0;
            r_dc    <= '0;
            r_esc   <= 1'b0;
            r_delim <= '0;
            r_first <= 1'b0;
            r_hdr   <= '0;
            r_err   <= '0;
        end else if (i_acc) begin
            r_err <= n_err;
            if (i_end_of_buffer) begin
                r_raw   <= '0;
                r_dc    <= '0;
                r_esc   <= 1'b0;
                r_delim <= '0;
                r_first <= 1'b0;
                r_hdr   <= '0;
            end else begin
                r_raw   <= n_raw;
                r_dc    <= n_dc;
                r_esc   <= n_esc;
                r_delim <= n_delim;
                r_first <= n_first;
                r_hdr   <= n_hdr;
            end
        end
    end

    // error count moves only by one step
    a_err_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_err != $past(r_err)) |-> (r_err == $past(r_err) + 16'd1))
        else $error("error counter jumped");

    // an escape is never left open across a buffer end
    a_esc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_end_of_buffer) |=> (!r_esc && r_raw == 8'd0))
        else $error("frame state not cleared at buffer end");

endmodule

>>> design/sfuc_outq.sv
module sfuc_outq import sfuc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_acc,
    input  t_bundle i_bundle,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_item   o_item
);

    logic [1:0]               r_cnt;
    t_item [MAX_RES-1:0]      r_slot;
    logic                     pop;
    logic                     load;

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[0];
    assign pop     = o_valid && i_ready;
    assign load    = i_acc && (i_bundle.count != 2'd0);
    // take new words when empty or once the last held word leaves this cycle
    assign o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    // hold count of waiting words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= i_bundle.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // load a new group or shift toward the head
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot <= i_bundle.items;
        end else if (pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)))
        else $error("group loaded over waiting words");

    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_slot[0].last)
        else $error("tail word of a group lacks last");

    a_head_notlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !r_slot[0].last)
        else $error("last flagged before end of group");

endmodule

>>> tb/sv/tb_slip_frame_unescape_check.sv
module tb_slip_frame_unescape_check;
    timeunit 1ns;
    timeprecision 1ps;

    import sfuc_pkg::*;

    localparam int unsigned HOLD_AT      = 60;
    localparam int unsigned HOLD_LEN     = 80;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS  = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       eob;
    } t_rx_word;

    // DUT ports, all inputs known from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = CFG_TYPE_NIBBLE;
    logic [7:0]           cfg_data   = 8'h00;
    logic                 in_valid   = 1'b0;
    logic [7:0]           in_byte    = 8'h00;
    logic                 in_eob     = 1'b0;
    logic                 out_ready  = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_item_kind;
    logic [7:0]           o_data_byte;
    logic [1:0]           o_frame_status;
    logic [7:0]           o_decoded_length;
    logic [15:0]          o_link_errors;
    logic                 o_last;

    // raw bytes waiting to be offered, decoded words waiting to come out
    t_rx_word    raw_bytes_todo[$];
    t_item       words_due[$];
    t_item       step_words[$];

    // shadow of the deframer state and registers
    logic [3:0]  type_sh       = TYPE_NIBBLE_RST;
    logic [7:0]  bias_sh       = LENGTH_BIAS_RST;
    logic [7:0]  fr_pos        = 8'd0;
    logic [7:0]  fr_decoded    = 8'd0;
    logic        esc_held      = 1'b0;
    logic [1:0]  delim_seen    = 2'd0;
    logic        opens_delim   = 1'b0;
    logic [7:0]  hdr_seen      = 8'd0;
    logic [15:0] link_err_cnt  = 16'd0;

    int unsigned accepted_words = 0;
    int unsigned hold_left      = 0;
    logic        hold_done      = 1'b0;
    logic        no_gaps        = 1'b0;
    int unsigned mismatches     = 0;
    t_rx_word    next_word;
    t_item       head_word;

    slip_frame_unescape_check DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (in_byte),
        .i_end_of_buffer  (in_eob),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_item_kind      (o_item_kind),
        .o_data_byte      (o_data_byte),
        .o_frame_status   (o_frame_status),
        .o_decoded_length (o_decoded_length),
        .o_link_errors    (o_link_errors),
        .o_last           (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Emit one decoded data word and count it against the frame length
    function automatic void emit_decoded(input logic [7:0] b);
        t_item w;
        w = '0;
        w.kind = KIND_DATA;
        w.data = b;
        step_words.push_back(w);
        if (fr_decoded != 8'hFF) fr_decoded = fr_decoded + 8'd1;
    endfunction

    // Unescape one raw byte and queue the words it is due to produce
    function automatic void slip_decode(input logic [7:0] b, input logic eob);
        t_item      w;
        logic [1:0] st;
        logic [8:0] want_len;
        if (fr_pos == 8'd0) opens_delim = (b == DELIM);
        if (fr_pos == HDR_POS) hdr_seen = b;
        if (fr_pos != 8'hFF) fr_pos = fr_pos + 8'd1;
        if (b == DELIM && delim_seen != 2'd3) delim_seen = delim_seen + 2'd1;

        if (esc_held) begin
            esc_held = 1'b0;
            if (b == ESC_ESC) begin
                emit_decoded(ESC);
            end else if (b == ESC_END) begin
                emit_decoded(DELIM);
            end else begin
                emit_decoded(ESC);
                if (b == ESC) esc_held = 1'b1;
                else emit_decoded(b);
            end
        end else if (b == ESC) begin
            esc_held = 1'b1;
        end else begin
            emit_decoded(b);
        end

        if (eob) begin
            // flush a dangling escape, then judge the frame
            if (esc_held) begin
                esc_held = 1'b0;
                emit_decoded(ESC);
            end
            if (delim_seen != 2'd2 || !opens_delim || b != DELIM) begin
                st = ST_IGNORED;
            end else if (hdr_seen[7:4] != type_sh) begin
                if (link_err_cnt != 16'hFFFF) link_err_cnt = link_err_cnt + 16'd1;
                st = ST_BAD_LINK;
            end else begin
                want_len = {5'd0, hdr_seen[3:0]} + {1'b0, bias_sh};
                st = ({1'b0, fr_decoded} == want_len) ? ST_OK : ST_LEN_BAD;
            end
            w = '0;
            w.kind   = KIND_STATUS;
            w.status = st;
            w.length = fr_decoded;
            w.errors = link_err_cnt;
            step_words.push_back(w);
            fr_pos      = 8'd0;
            fr_decoded  = 8'd0;
            delim_seen  = 2'd0;
            opens_delim = 1'b0;
            hdr_seen    = 8'd0;
        end

        // mark the final word of this byte
        if (step_words.size() != 0) begin
            w = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
        while (step_words.size() != 0) words_due.push_back(step_words.pop_front());
    endfunction

    function automatic void queue_byte(input logic [7:0] value, input logic eob);
        t_rx_word r;
        r.value = value;
        r.eob   = eob;
        raw_bytes_todo.push_back(r);
    endfunction

    // Any byte that is neither a delimiter nor an escape
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == DELIM || b == ESC);
        return b;
    endfunction

    // Well-formed frame; aim_ok steers the decoded length onto the expected one,
    // loose allows escapes that pass the following byte through
    function automatic void queue_frame(input logic aim_ok, input logic loose);
        logic [3:0]  hi;
        logic [3:0]  lo;
        int unsigned sum;
        int unsigned target;
        int unsigned left;
        int unsigned pick;
        hi = ($urandom_range(99) < 85) ? type_sh : 4'($urandom_range(15));
        lo = 4'($urandom_range(15));
        sum = 32'(lo) + 32'(bias_sh);
        if (aim_ok && sum >= 8 && sum <= 48) target = sum;
        else target = $urandom_range(2, 40);

        queue_byte(DELIM, 1'b0);
        if (target < 8) begin
            // too short for a header byte ahead of the closing delimiter
            repeat (target - 2) queue_byte(plain_byte(), 1'b0);
            queue_byte(DELIM, 1'b1);
            return;
        end
        repeat (5) queue_byte(plain_byte(), 1'b0);
        queue_byte({hi, lo}, 1'b0);
        left = target - 8;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                queue_byte(ESC, 1'b0);
                queue_byte(ESC_ESC, 1'b0);
            end else if (pick < 24) begin
                queue_byte(ESC, 1'b0);
                queue_byte(ESC_END, 1'b0);
            end else if (loose && pick < 30 && left >= 2) begin
                queue_byte(ESC, 1'b0);
                queue_byte(plain_byte(), 1'b0);
                left = left - 1;
            end else begin
                queue_byte(plain_byte(), 1'b0);
            end
            left = left - 1;
        end
        queue_byte(DELIM, 1'b1);
    endfunction

    // Broken buffers rich in delimiters and escapes
    function automatic void queue_noise(input int unsigned n);
        logic [7:0]  b;
        int unsigned pick;
        for (int unsigned i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 25) b = DELIM;
            else if (pick < 45) b = ESC;
            else if (pick < 52) b = ESC_ESC;
            else if (pick < 59) b = ESC_END;
            else b = 8'($urandom_range(255));
            queue_byte(b, (i == n - 1) ? ($urandom_range(99) < 70) : ($urandom_range(99) < 8));
        end
    endfunction

    function automatic void queue_random(input int unsigned n);
        int unsigned stop_at;
        stop_at = raw_bytes_todo.size() + n;
        while (raw_bytes_todo.size() < stop_at) begin
            if ($urandom_range(99) < 80) begin
                queue_frame($urandom_range(99) < 60, 1'($urandom_range(1)));
            end else begin
                queue_noise($urandom_range(3, 12));
            end
        end
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TYPE_NIBBLE) type_sh = value[3:0];
        else bias_sh = value;
        @(negedge i_clk);
    endtask

    // Hold until every byte is taken and every due word has come, then drain
    task automatic wait_idle();
        do @(negedge i_clk);
        while (raw_bytes_todo.size() != 0 || in_valid || words_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Sender: predict each accepted word, then offer the next one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                slip_decode(in_byte, in_eob);
                accepted_words <= accepted_words + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (raw_bytes_todo.size() != 0 && (no_gaps || $urandom_range(99) >= 34)) begin
                    next_word = raw_bytes_todo.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= next_word.value;
                    in_eob   <= next_word.eob;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && accepted_words >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_gaps || ($urandom_range(99) >= 34);
        end
    end

    // Compare each output word with the oldest due word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (words_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: word expected none, got kind %0h data %0h status %0h",
                             $time, o_item_kind, o_data_byte, o_frame_status);
            end else begin
                head_word = words_due.pop_front();
                check_field("item_kind", 16'(head_word.kind), 16'(o_item_kind));
                check_field("data_byte", 16'(head_word.data), 16'(o_data_byte));
                check_field("frame_status", 16'(head_word.status), 16'(o_frame_status));
                check_field("decoded_length", 16'(head_word.length), 16'(o_decoded_length));
                check_field("link_errors", head_word.errors, o_link_errors);
                check_field("last", 16'(head_word.last), 16'(o_last));
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // shortest frame: no header byte, so a bad link under the reset type
        queue_byte(DELIM, 1'b0);
        queue_byte(DELIM, 1'b1);
        // escape passing the next byte through, three words on the end byte
        queue_byte(8'h41, 1'b0);
        queue_byte(ESC, 1'b0);
        queue_byte(8'h42, 1'b1);
        // escape still pending at the end of the buffer
        queue_byte(ESC, 1'b0);
        queue_byte(ESC, 1'b1);
        // good frame whose length matches the header
        queue_byte(DELIM, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h04, 1'b0);
        queue_byte(8'h50, 1'b0);
        queue_byte(ESC, 1'b0);
        queue_byte(ESC_ESC, 1'b0);
        queue_byte(ESC, 1'b0);
        queue_byte(ESC_END, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(DELIM, 1'b1);
        // too many delimiters
        repeat (3) queue_byte(DELIM, 1'b0);
        queue_byte(DELIM, 1'b1);
        wait_idle();

        // low extremes; the long receiver hold-off falls in this phase
        write_reg(CFG_TYPE_NIBBLE, {4'($urandom_range(15)), 4'h0});
        write_reg(CFG_LENGTH_BIAS, 8'd0);
        queue_random(55);
        wait_idle();

        write_reg(CFG_TYPE_NIBBLE, {4'($urandom_range(15)), 4'($urandom_range(15))});
        write_reg(CFG_LENGTH_BIAS, 8'($urandom_range(3, 30)));
        queue_random(55);
        wait_idle();

        // high extremes: expected length overflows a byte for any nonzero low nibble; no gaps on either side
        write_reg(CFG_TYPE_NIBBLE, 8'h0F);
        write_reg(CFG_LENGTH_BIAS, 8'd255);
        no_gaps = 1'b1;
        queue_random(55);
        wait_idle();
        no_gaps = 1'b0;

        write_reg(CFG_TYPE_NIBBLE, 8'h09);
        write_reg(CFG_LENGTH_BIAS, 8'd20);
        queue_random(55);
        wait_idle();

        if (mismatches == 0) begin
            $display("tb_slip_frame_unescape_check: done, clean");
        end else begin
            $display("tb_slip_frame_unescape_check: done, errors");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #2ms;
        $display("tb_slip_frame_unescape_check: done, errors");
        $finish;
    end

endmodule
